// ----- hdl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    localparam int HUE_W     = 16;
    localparam int CH_W      = 8;
    localparam int Q_W       = 9;
    localparam int CFG_IDX_W = 2;
    localparam int SECT_W    = 3;

    localparam logic [Q_W-1:0] Q_ONE = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE      = 2'd1;

    localparam logic [Q_W-1:0] SATURATION_RST = 9'd256;
    localparam logic [Q_W-1:0] VALUE_RST      = 9'd77;
    // c = (77 * 256) >> 8 at reset
    localparam logic [Q_W-1:0] CHROMA_RST     = 9'd77;

    localparam logic [SECT_W-1:0] SECT_RED_UP   = 3'd0;
    localparam logic [SECT_W-1:0] SECT_RED_DN   = 3'd1;
    localparam logic [SECT_W-1:0] SECT_BLUE_UP  = 3'd2;
    localparam logic [SECT_W-1:0] SECT_GREEN_DN = 3'd3;
    localparam logic [SECT_W-1:0] SECT_RED_UP2  = 3'd4;
    localparam logic [SECT_W-1:0] SECT_LAST     = 3'd5;

    typedef struct packed {
        logic [Q_W-1:0] c;
        logic [Q_W-1:0] v;
        logic [Q_W-1:0] m;
    } chroma_t;

    // floor(level * 255 / 256), held at 255
    function automatic logic [CH_W-1:0] to_channel(input logic [Q_W-1:0] level);
        logic [Q_W+CH_W-1:0] p;
        logic [Q_W-1:0]      o;
        p = {level, 8'd0} - {8'd0, level};
        o = p[Q_W+CH_W-1:CH_W];
        return (o > 9'd255) ? 8'd255 : o[CH_W-1:0];
    endfunction

endpackage

// ----- hdl/hsv2rgb_if.sv -----
interface hsv2rgb_hue_if import hsv2rgb_pkg::*;;
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;

    modport source (output valid, output hue, input ready);
    modport sink   (input valid, input hue, output ready);
endinterface

interface hsv2rgb_rgb_if import hsv2rgb_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hdl/hsv2rgb_cfg.sv -----
module hsv2rgb_cfg import hsv2rgb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [Q_W-1:0]       wr_data,
    output chroma_t              chroma
);

    logic [Q_W-1:0]     sat_reg;
    logic [Q_W-1:0]     val_reg;
    logic [Q_W-1:0]     c_reg;
    logic [Q_W-1:0]     v_reg;
    logic [Q_W-1:0]     c_next;
    logic [Q_W-1:0]     v_next;
    logic [Q_W-1:0]     s_clamp;
    logic [2*Q_W-1:0]   vs_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= SATURATION_RST;
            val_reg <= VALUE_RST;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_SATURATION)
                sat_reg <= wr_data;
            else if (wr_index == REG_VALUE)
                val_reg <= wr_data;
        end
    end

    always_comb
    begin
        s_clamp = (sat_reg > Q_ONE) ? Q_ONE : sat_reg;
        v_next  = (val_reg > Q_ONE) ? Q_ONE : val_reg;
        vs_prod = v_next * s_clamp;
        c_next  = vs_prod[2*Q_W-2:8];
    end

    // chroma settles via config and chroma registers; the user keeps words out till then
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= CHROMA_RST;
            v_reg <= VALUE_RST;
        end
        else
        begin
            c_reg <= c_next;
            v_reg <= v_next;
        end
    end

    assign chroma.c = c_reg;
    assign chroma.v = v_reg;
    assign chroma.m = v_reg - c_reg;

endmodule

// ----- hdl/hsv_to_rgb_pixel_core.sv -----
// HSV to RGB pixel converter. Each hue word (a 16-bit fraction of a turn) becomes one
// 8-bit RGB triple through the six-sector formula, with saturation and value taken
// from configuration registers 0 and 1 (Q1.8, 256 = 1.0, larger values act as 256).
// The core accepts one hue every clock unless the output holds it back, and delivers each
// color through three registered stages (sector split, hue fraction multiply, component
// select and scale). Backpressure on the output stalls the stages in place without loss.
// Chroma is recomputed through the configuration register and then the chroma register
// after a register write, so write configuration only while no word is in flight.
module hsv_to_rgb_pixel_core import hsv2rgb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    hsv2rgb_hue_if.sink          hue_ch,
    hsv2rgb_rgb_if.source        rgb_ch,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [Q_W-1:0]       wr_data
);

    chroma_t chroma;

    hsv2rgb_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .chroma   (chroma)
    );

    // stage control
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic ld1, ld2, ld3;

    assign ld3 = !v3_reg || rgb_ch.ready;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign hue_ch.ready = ld1;

    always_comb
    begin
        v1_next = ld1 ? hue_ch.valid : v1_reg;
        v2_next = ld2 ? v1_reg : v2_reg;
        v3_next = ld3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // stage 1: hue * 6 into sector and fraction
    logic [HUE_W+2:0]    h6;
    logic [SECT_W-1:0]   sect1_reg;
    logic [HUE_W-1:0]    frac1_reg;

    assign h6 = {1'b0, hue_ch.hue, 2'b00} + {2'b00, hue_ch.hue, 1'b0};

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            sect1_reg <= h6[HUE_W+2:HUE_W];
            frac1_reg <= h6[HUE_W-1:0];
        end
    end

    // stage 2: second component x = c * f or c * (1 - f)
    logic [HUE_W:0]       ramp;
    logic [Q_W+HUE_W:0]   x_prod;
    logic [SECT_W-1:0]    sect2_reg;
    logic [Q_W-1:0]       x2_reg;

    always_comb
    begin
        if (sect1_reg[0])
            ramp = {1'b1, {HUE_W{1'b0}}} - {1'b0, frac1_reg};
        else
            ramp = {1'b0, frac1_reg};
        x_prod = chroma.c * ramp;
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            sect2_reg <= sect1_reg;
            x2_reg    <= x_prod[Q_W+HUE_W-1:HUE_W];
        end
    end

    // stage 3: place components, lift by m, scale to 8 bits
    logic [Q_W-1:0]  r_lvl, g_lvl, b_lvl;
    logic [Q_W-1:0]  r_cmp, g_cmp, b_cmp;
    logic [CH_W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        unique case (sect2_reg)
            SECT_RED_UP:
            begin
                r_cmp = chroma.c; g_cmp = x2_reg;   b_cmp = '0;
            end
            SECT_RED_DN:
            begin
                r_cmp = x2_reg;   g_cmp = chroma.c; b_cmp = '0;
            end
            SECT_BLUE_UP:
            begin
                r_cmp = '0;       g_cmp = chroma.c; b_cmp = x2_reg;
            end
            SECT_GREEN_DN:
            begin
                r_cmp = '0;       g_cmp = x2_reg;   b_cmp = chroma.c;
            end
            SECT_RED_UP2:
            begin
                r_cmp = x2_reg;   g_cmp = '0;       b_cmp = chroma.c;
            end
            default:
            begin
                r_cmp = chroma.c; g_cmp = '0;       b_cmp = x2_reg;
            end
        endcase
        r_lvl = r_cmp + chroma.m;
        g_lvl = g_cmp + chroma.m;
        b_lvl = b_cmp + chroma.m;
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            red_reg   <= to_channel(r_lvl);
            green_reg <= to_channel(g_lvl);
            blue_reg  <= to_channel(b_lvl);
        end
    end

    assign rgb_ch.valid = v3_reg;
    assign rgb_ch.red   = red_reg;
    assign rgb_ch.green = green_reg;
    assign rgb_ch.blue  = blue_reg;

`ifndef SYNTHESIS
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (sect1_reg <= SECT_LAST))
        else $error("sector out of range");

    a_x_below_c: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (x2_reg <= chroma.c))
        else $error("second component exceeds chroma");

    a_peak_is_value: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_ch.valid |-> (rgb_ch.red == to_channel(chroma.v)
                          || rgb_ch.green == to_channel(chroma.v)
                          || rgb_ch.blue == to_channel(chroma.v)))
        else $error("no channel carries the value level");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (hue_ch.valid && hue_ch.ready) |=> v1_reg)
        else $error("accepted word lost at entry");
`endif

endmodule

// ----- dv/hsv_to_rgb_pixel_core_tb.sv -----
module hsv_to_rgb_pixel_core_tb;
    import hsv2rgb_pkg::*;

    localparam int PIPE_LAT        = 3;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int STALL_LIMIT     = 4000;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_WORDS     = 100;

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [Q_W-1:0]       wr_data;

    hsv2rgb_hue_if hue_ch ();
    hsv2rgb_rgb_if rgb_ch ();

    logic [Q_W-1:0] sat_shadow;
    logic [Q_W-1:0] val_shadow;
    rgb_word_t      pending_rgb[$];
    int             mismatch_cnt = 0;
    int             idle_cycles  = 0;
    bit             src_gaps;
    bit             sink_gaps;
    bit             hold_off_req;

    hsv_to_rgb_pixel_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .hue_ch   (hue_ch),
        .rgb_ch   (rgb_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #4 clk = ~clk;

    // floor(level * 255 / 256), held at 255
    function automatic logic [CH_W-1:0] level_to_byte(input logic [Q_W-1:0] level);
        logic [Q_W+CH_W-1:0] scaled;
        logic [Q_W-1:0]      top;
        scaled = {8'd0, level} * 17'd255;
        top    = scaled[Q_W+CH_W-1:CH_W];
        return (top > 9'd255) ? 8'd255 : top[CH_W-1:0];
    endfunction

    function automatic rgb_word_t hue_to_rgb(input logic [HUE_W-1:0] hue);
        logic [Q_W-1:0]     s;
        logic [Q_W-1:0]     v;
        logic [2*Q_W-1:0]   vs;
        logic [Q_W-1:0]     c;
        logic [Q_W-1:0]     m;
        logic [Q_W-1:0]     x;
        logic [HUE_W+2:0]   h6;
        logic [SECT_W-1:0]  sector;
        logic [HUE_W-1:0]   frac;
        logic [HUE_W:0]     weight;
        logic [Q_W+HUE_W:0] prod;
        logic [Q_W-1:0]     r;
        logic [Q_W-1:0]     g;
        logic [Q_W-1:0]     b;
        rgb_word_t          rgb;
        s      = (sat_shadow > Q_ONE) ? Q_ONE : sat_shadow;
        v      = (val_shadow > Q_ONE) ? Q_ONE : val_shadow;
        vs     = v * s;
        c      = vs[Q_W+7:8];
        m      = v - c;
        h6     = hue * 3'd6;
        sector = h6[HUE_W+2:HUE_W];
        frac   = h6[HUE_W-1:0];
        // odd sectors ramp down
        weight = sector[0] ? (17'h10000 - frac) : {1'b0, frac};
        prod   = c * weight;
        x      = prod[Q_W+HUE_W-1:HUE_W];
        case (sector)
            SECT_RED_UP:   begin r = c;  g = x;  b = '0; end
            SECT_RED_DN:   begin r = x;  g = c;  b = '0; end
            SECT_BLUE_UP:  begin r = '0; g = c;  b = x;  end
            SECT_GREEN_DN: begin r = '0; g = x;  b = c;  end
            SECT_RED_UP2:  begin r = x;  g = '0; b = c;  end
            default:       begin r = c;  g = '0; b = x;  end
        endcase
        rgb.red   = level_to_byte(r + m);
        rgb.green = level_to_byte(g + m);
        rgb.blue  = level_to_byte(b + m);
        return rgb;
    endfunction

    // favor hues close to the sector boundaries
    function automatic logic [HUE_W-1:0] random_hue();
        int boundary;
        if ($urandom_range(3) != 0)
            return HUE_W'($urandom_range(65535));
        boundary = int'(($urandom_range(5) * 65536 + 5) / 6) + int'($urandom_range(4)) - 2;
        if (boundary < 0)
            boundary = 0;
        return boundary[HUE_W-1:0];
    endfunction

    task automatic send_hue(input logic [HUE_W-1:0] hue);
        while (src_gaps && $urandom_range(99) < 32)
        begin
            hue_ch.valid <= 1'b0;
            @(posedge clk);
        end
        hue_ch.valid <= 1'b1;
        hue_ch.hue   <= hue;
        do @(posedge clk); while (!hue_ch.ready);
        pending_rgb.push_back(hue_to_rgb(hue));
    endtask

    task automatic wait_results_done();
        hue_ch.valid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [Q_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        if (index == REG_SATURATION)
            sat_shadow = data;
        else if (index == REG_VALUE)
            val_shadow = data;
    endtask

    // drain, let the pipe settle, write two registers, let chroma settle
    task automatic apply_writes(input logic [CFG_IDX_W-1:0] idx_a, input logic [Q_W-1:0] data_a,
                                input logic [CFG_IDX_W-1:0] idx_b, input logic [Q_W-1:0] data_b);
        wait_results_done();
        repeat (PIPE_LAT + 2) @(posedge clk);
        write_reg(idx_a, data_a);
        write_reg(idx_b, data_b);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [HUE_W-1:0] corner_hues[$] = '{16'h0000, 16'hFFFF, 16'h0001, 16'd10922,
                                             16'd10923, 16'd21845, 16'd21846, 16'd32768,
                                             16'd43690, 16'd43691, 16'd54613, 16'd54614};
        logic [HUE_W-1:0] probe_hues[$] = '{16'h0000, 16'd10923, 16'h5555, 16'hAAAA};
        foreach (corner_hues[i])
            send_hue(corner_hues[i]);
        // full scale: channel sums reach 256
        apply_writes(REG_SATURATION, Q_ONE, REG_VALUE, Q_ONE);
        foreach (probe_hues[i])
            send_hue(probe_hues[i]);
        apply_writes(REG_SATURATION, 9'd511, REG_VALUE, 9'd511);
        foreach (probe_hues[i])
            send_hue(probe_hues[i]);
        // these must leave both registers alone
        apply_writes(REG_UNUSED_A, 9'd0, REG_UNUSED_B, 9'd0);
        foreach (probe_hues[i])
            send_hue(16'hFFFF - probe_hues[i]);
    endtask

    task automatic test_random_sweep();
        logic [Q_W-1:0] sat_set[$] = '{9'd0, 9'd0, 9'd256, 9'd511, 9'd1};
        logic [Q_W-1:0] val_set[$] = '{9'd0, 9'd256, 9'd0, 9'd300, 9'd255};
        logic [Q_W-1:0] sat;
        logic [Q_W-1:0] val;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < sat_set.size())
            begin
                sat = sat_set[phase];
                val = val_set[phase];
            end
            else
            begin
                sat = Q_W'($urandom_range(511));
                val = Q_W'($urandom_range(511));
            end
            apply_writes(REG_SATURATION, sat, REG_VALUE, val);
            repeat (PHASE_WORDS) send_hue(random_hue());
        end
    endtask

    task automatic test_back_pressure();
        apply_writes(REG_SATURATION, Q_W'($urandom_range(256)),
                     REG_VALUE, Q_W'($urandom_range(256)));
        src_gaps     = 1'b0;
        hold_off_req = 1'b1;
        repeat (48) send_hue(random_hue());
        wait_results_done();
        src_gaps = 1'b1;
    endtask

    task automatic test_streaming();
        apply_writes(REG_VALUE, Q_W'($urandom_range(511)),
                     REG_SATURATION, Q_W'($urandom_range(511)));
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        repeat (180) send_hue(random_hue());
        wait_results_done();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic flag_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : check_rgb
        rgb_word_t want;
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
        begin
            if (pending_rgb.size() == 0)
            begin
                flag_error($sformatf("unexpected rgb word r=%0d g=%0d b=%0d",
                                     rgb_ch.red, rgb_ch.green, rgb_ch.blue));
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (rgb_ch.red !== want.red || rgb_ch.green !== want.green ||
                    rgb_ch.blue !== want.blue)
                    flag_error($sformatf("rgb expected %0d/%0d/%0d got %0d/%0d/%0d",
                                         want.red, want.green, want.blue,
                                         rgb_ch.red, rgb_ch.green, rgb_ch.blue));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            // hold the output long enough for the pipe to fill and stall its input
            rgb_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_off_req = 1'b0;
        end
        else
        begin
            rgb_ch.ready <= !(sink_gaps && $urandom_range(99) < 32);
        end
    end

    always @(posedge clk)
    begin
        if ((hue_ch.valid && hue_ch.ready) || (rgb_ch.valid && rgb_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        wr_en        <= 1'b0;
        wr_index     <= REG_SATURATION;
        wr_data      <= '0;
        hue_ch.valid <= 1'b0;
        hue_ch.hue   <= '0;
        rgb_ch.ready <= 1'b0;
        sat_shadow   = SATURATION_RST;
        val_shadow   = VALUE_RST;
        src_gaps     = 1'b1;
        sink_gaps    = 1'b1;
        hold_off_req = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_sweep();
        test_back_pressure();
        test_streaming();

        wait_results_done();
        repeat (PIPE_LAT + 8) @(posedge clk);
        if (mismatch_cnt == 0 && pending_rgb.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- hsv_to_rgb_pixel_core.f -----
hdl/hsv2rgb_pkg.sv
hdl/hsv2rgb_if.sv
hdl/hsv2rgb_cfg.sv
hdl/hsv_to_rgb_pixel_core.sv
dv/hsv_to_rgb_pixel_core_tb.sv
